### rtl/core/tppc_pkg.sv
// Shared types and constants for the TCP port payload capture block.
package tppc_pkg;

  // Frame byte offsets (Ethernet + fixed 20-byte IPv4 header)
  localparam int unsigned EtherTypeHiOff = 12;
  localparam int unsigned EtherTypeLoOff = 13;
  localparam int unsigned IpProtoOff     = 23;
  localparam int unsigned SrcIpFirstOff  = 26;
  localparam int unsigned SrcIpLastOff   = 29;
  localparam int unsigned DstIpFirstOff  = 30;
  localparam int unsigned DstIpLastOff   = 33;
  localparam int unsigned TcpBase        = 34;
  localparam int unsigned SrcPortLastOff = 35;
  localparam int unsigned DstPortFirstOff = 36;
  localparam int unsigned DstPortLastOff = 37;
  localparam int unsigned DoffOff        = 46;
  localparam int unsigned MinFrame       = 54;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;

  // Configuration register indexes
  localparam logic CFG_TARGET_PORT = 1'b0;
  localparam logic CFG_PORT_ON     = 1'b1;

  // Result item kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Result tdata layout
  localparam int unsigned OUT_TDATA_W = 168;

  // Header fields handed from the parser to the reader
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    logic        bank;
  } hdr_t;

endpackage

### rtl/core/tcp_port_payload_capture_core.sv
// Top level of the TCP port payload capture block.
//
// Frame bytes enter one per cycle. Matching IPv4/TCP frames (source or
// destination port equal to the target port, port enabled, non-empty payload)
// give a record after the frame's last byte: one header item, then
// ceil(CAPTURE_BYTES/8) payload words, one item per cycle when the sink is
// ready. Payload bytes are written into one bank of a two-bank buffer memory
// of 32-bit rows while the previous record is read from the other bank; the
// reader takes two rows per word through two registered read ports. The last
// byte of a matching frame waits while the previous record is still being
// read out; all other bytes are taken every cycle. The buffer needs no
// clearing pass, since bytes beyond the captured size are masked to zero.
module tcp_port_payload_capture_core #(
  parameter int unsigned CAPTURE_BYTES   = 64,
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // data_byte
  input  logic                             s_axis_tlast,  // frame_end
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // source IP, destination IP, source port, destination port, captured size,
  // payload word, zero pad
  output logic [tppc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,  // record_kind
  output logic                             m_axis_tlast,  // record_last
  input  logic                             cfg_we_i,
  input  logic                             cfg_addr_i,
  input  logic [15:0]                      cfg_wdata_i
);
  import tppc_pkg::*;

  localparam int unsigned WORDS = (CAPTURE_BYTES + 7) / 8;
  localparam int unsigned DEPTH = 15 + 2 * WORDS;
  localparam int unsigned RW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(CAPTURE_BYTES + 1);

  hdr_t          hdr;
  logic [SW-1:0] size;
  logic          start;
  logic          busy;
  logic          wr_en;
  logic          wr_bank;
  logic [RW-1:0] wr_row;
  logic [1:0]    wr_lane;
  logic [7:0]    wr_byte;
  logic          rd_en;
  logic          rd_bank;
  logic [RW-1:0] rd_row0;
  logic [RW-1:0] rd_row1;
  logic [31:0]   rd_data0;
  logic [31:0]   rd_data1;

  tppc_parser #(
    .CAPTURE_BYTES   (CAPTURE_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .DEPTH           (DEPTH),
    .RW              (RW),
    .SW              (SW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .s_tready_o  (s_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_i      (busy),
    .start_o     (start),
    .hdr_o       (hdr),
    .size_o      (size),
    .wr_en_o     (wr_en),
    .wr_bank_o   (wr_bank),
    .wr_row_o    (wr_row),
    .wr_lane_o   (wr_lane),
    .wr_byte_o   (wr_byte)
  );

  tppc_buffer #(
    .DEPTH (DEPTH),
    .RW    (RW)
  ) u_buffer (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_bank_i  (wr_bank),
    .wr_row_i   (wr_row),
    .wr_lane_i  (wr_lane),
    .wr_byte_i  (wr_byte),
    .rd_en_i    (rd_en),
    .rd_bank_i  (rd_bank),
    .rd_row0_i  (rd_row0),
    .rd_row1_i  (rd_row1),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  tppc_reader #(
    .WORDS (WORDS),
    .RW    (RW),
    .SW    (SW)
  ) u_reader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .hdr_i      (hdr),
    .size_i     (size),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_bank_o  (rd_bank),
    .rd_row0_o  (rd_row0),
    .rd_row1_o  (rd_row1),
    .rd_data0_i (rd_data0),
    .rd_data1_i (rd_data1),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

### rtl/core/tppc_buffer.sv
// Two-bank payload byte buffer: byte-lane write port, two registered row read ports.
module tppc_buffer #(
  parameter int unsigned DEPTH = 31,
  parameter int unsigned RW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic          wr_bank_i,
  input  logic [RW-1:0] wr_row_i,
  input  logic [1:0]    wr_lane_i,
  input  logic [7:0]    wr_byte_i,
  input  logic          rd_en_i,
  input  logic          rd_bank_i,
  input  logic [RW-1:0] rd_row0_i,
  input  logic [RW-1:0] rd_row1_i,
  output logic [31:0]   rd_data0_o,
  output logic [31:0]   rd_data1_o
);

  logic [3:0][7:0] mem_q [0:1][0:DEPTH-1];
  logic [31:0]     rd0_q;
  logic [31:0]     rd1_q;

  // Write one byte lane of a row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_bank_i][wr_row_i][wr_lane_i] <= wr_byte_i;
    end
  end

  // Read two rows, hold while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd0_q <= mem_q[rd_bank_i][rd_row0_i];
      rd1_q <= mem_q[rd_bank_i][rd_row1_i];
    end
  end

  assign rd_data0_o = rd0_q;
  assign rd_data1_o = rd1_q;

endmodule

### rtl/core/tppc_parser.sv
// Frame parser: byte offset tracking, header field capture, match decision, buffer writes.
module tppc_parser #(
  parameter int unsigned CAPTURE_BYTES   = 64,
  parameter int unsigned MAX_FRAME_BYTES = 2048,
  parameter int unsigned DEPTH           = 31,
  parameter int unsigned RW              = 5,
  parameter int unsigned SW              = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic [7:0]           s_tdata_i,
  input  logic                 s_tlast_i,
  output logic                 s_tready_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 busy_i,
  output logic                 start_o,
  output tppc_pkg::hdr_t       hdr_o,
  output logic [SW-1:0]        size_o,
  output logic                 wr_en_o,
  output logic                 wr_bank_o,
  output logic [RW-1:0]        wr_row_o,
  output logic [1:0]           wr_lane_o,
  output logic [7:0]           wr_byte_o
);
  import tppc_pkg::*;

  localparam int unsigned OFFW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned XW0  = (OFFW > RW + 2) ? OFFW : RW + 2;
  localparam int unsigned XW   = (XW0 > SW) ? XW0 : SW;

  logic [OFFW-1:0] off_q;
  logic            rej_q;
  logic [3:0]      doff_q;
  logic            bank_q;
  logic [15:0]     tport_q;
  logic            port_on_q;
  logic [7:0]      eth_hi_q;
  logic [31:0]     src_ip_q;
  logic [31:0]     dst_ip_q;
  logic [15:0]     sport_q;
  logic [15:0]     dport_q;

  logic            acc;
  logic            room;
  logic            take;
  logic [XW-1:0]   off_x;
  logic [XW-1:0]   len_x;
  logic [XW-1:0]   start_x;
  logic [XW-1:0]   pay_len;
  logic [XW-1:0]   rel_x;
  logic            port_hit;
  logic            ok;

  // Frame length and payload start as seen at this byte
  assign room     = (off_q < OFFW'(MAX_FRAME_BYTES));
  assign off_x    = XW'(off_q);
  assign len_x    = off_x + XW'(room);
  assign start_x  = XW'(TcpBase) + (XW'(doff_q) << 2);
  assign pay_len  = len_x - start_x;
  assign port_hit = port_on_q && ((sport_q == tport_q) || (dport_q == tport_q));
  assign ok       = (len_x >= XW'(MinFrame)) && !rej_q && port_hit && (len_x > start_x);

  // Hold a matching frame end while the previous record is still read out
  assign s_tready_o = !(s_tlast_i && ok && busy_i);
  assign acc        = s_tvalid_i && s_tready_o;
  assign take       = acc && room;

  assign start_o = acc && s_tlast_i && ok;
  assign size_o  = (pay_len > XW'(CAPTURE_BYTES)) ? SW'(CAPTURE_BYTES) : SW'(pay_len);

  assign hdr_o.src_ip = src_ip_q;
  assign hdr_o.dst_ip = dst_ip_q;
  assign hdr_o.sport  = sport_q;
  assign hdr_o.dport  = dport_q;
  assign hdr_o.doff   = doff_q;
  assign hdr_o.bank   = bank_q;

  // Store every byte from the TCP header on that fits in the buffer, indexed relative to its start
  assign rel_x     = off_x - XW'(TcpBase);
  assign wr_en_o   = take && (off_x >= XW'(TcpBase)) && (rel_x < XW'(4 * DEPTH));
  assign wr_bank_o = bank_q;
  assign wr_row_o  = rel_x[RW+1:2];
  assign wr_lane_o = rel_x[1:0];
  assign wr_byte_o = s_tdata_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tport_q   <= '0;
      port_on_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_TARGET_PORT: tport_q   <= cfg_wdata_i;
        CFG_PORT_ON:     port_on_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance offset, flag rejects, take doff; clear at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      rej_q  <= 1'b0;
      doff_q <= '0;
      bank_q <= 1'b0;
    end else if (acc) begin
      if (s_tlast_i) begin
        off_q  <= '0;
        rej_q  <= 1'b0;
        doff_q <= '0;
        if (ok) begin
          bank_q <= !bank_q;
        end
      end else if (take) begin
        off_q <= off_q + OFFW'(1);
        if (off_q == OFFW'(EtherTypeLoOff) && {eth_hi_q, s_tdata_i} != ETH_TYPE_IPV4) begin
          rej_q <= 1'b1;
        end
        if (off_q == OFFW'(IpProtoOff) && s_tdata_i != IP_PROTO_TCP) begin
          rej_q <= 1'b1;
        end
        if (off_q == OFFW'(DoffOff)) begin
          doff_q <= s_tdata_i[7:4];
        end
      end
    end
  end

  // Shift in the ethertype high byte, addresses and ports
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (off_q == OFFW'(EtherTypeHiOff)) begin
        eth_hi_q <= s_tdata_i;
      end
      if (off_q >= OFFW'(SrcIpFirstOff) && off_q <= OFFW'(SrcIpLastOff)) begin
        src_ip_q <= {src_ip_q[23:0], s_tdata_i};
      end
      if (off_q >= OFFW'(DstIpFirstOff) && off_q <= OFFW'(DstIpLastOff)) begin
        dst_ip_q <= {dst_ip_q[23:0], s_tdata_i};
      end
      if (off_q >= OFFW'(TcpBase) && off_q <= OFFW'(SrcPortLastOff)) begin
        sport_q <= {sport_q[7:0], s_tdata_i};
      end
      if (off_q >= OFFW'(DstPortFirstOff) && off_q <= OFFW'(DstPortLastOff)) begin
        dport_q <= {dport_q[7:0], s_tdata_i};
      end
    end
  end

endmodule

### rtl/core/tppc_reader.sv
// Record reader: steps through header and payload words, output register stage.
module tppc_reader #(
  parameter int unsigned WORDS = 8,
  parameter int unsigned RW    = 5,
  parameter int unsigned SW    = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  tppc_pkg::hdr_t                     hdr_i,
  input  logic [SW-1:0]                      size_i,
  output logic                               busy_o,
  output logic                               rd_en_o,
  output logic                               rd_bank_o,
  output logic [RW-1:0]                      rd_row0_o,
  output logic [RW-1:0]                      rd_row1_o,
  input  logic [31:0]                        rd_data0_i,
  input  logic [31:0]                        rd_data1_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [tppc_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  output logic                               m_tuser_o,
  output logic                               m_tlast_o
);
  import tppc_pkg::*;

  localparam int unsigned STW = $clog2(WORDS + 1);
  localparam int unsigned BW  = STW + 3;

  hdr_t           rec_q;
  logic [SW-1:0]  size_q;
  logic           active_q;
  logic [STW-1:0] step_q;
  logic           vld_q;
  logic           kind_q;
  logic           last_q;
  logic [7:0]     mask_q;

  logic           adv;
  logic           issue;
  logic [STW-1:0] wi;
  logic [7:0]     mask_d;
  logic [63:0]    row_pair;
  logic [63:0]    word;

  assign adv   = !vld_q || m_tready_i;
  assign issue = adv && active_q;
  assign wi    = step_q - STW'(1);

  // Two rows of four bytes make one payload word
  assign rd_en_o   = issue && (step_q != '0);
  assign rd_bank_o = rec_q.bank;
  assign rd_row0_o = RW'(rec_q.doff) + RW'({wi, 1'b0});
  assign rd_row1_o = RW'(rec_q.doff) + RW'({wi, 1'b1});
  assign busy_o    = active_q;

  // Keep only bytes below the captured size
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask_d[k] = ({wi, 3'(k)} < BW'(size_q));
    end
  end

  // Latch the record and step through its items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      vld_q    <= 1'b0;
      kind_q   <= KIND_HEADER;
      last_q   <= 1'b0;
    end else begin
      if (start_i) begin
        active_q <= 1'b1;
        step_q   <= '0;
      end else if (issue) begin
        step_q <= step_q + STW'(1);
        if (step_q == STW'(WORDS)) begin
          active_q <= 1'b0;
        end
      end
      if (issue) begin
        vld_q  <= 1'b1;
        kind_q <= (step_q != '0) ? KIND_PAYLOAD : KIND_HEADER;
        last_q <= (step_q == STW'(WORDS));
      end else if (adv) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Record fields and byte mask
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rec_q  <= hdr_i;
      size_q <= size_i;
    end
    if (issue) begin
      mask_q <= mask_d;
    end
  end

  // Assemble the payload word, earliest byte lowest
  assign row_pair = {rd_data1_i, rd_data0_i};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      word[8*k +: 8] = mask_q[k] ? row_pair[8*k +: 8] : 8'h00;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tuser_o  = kind_q;
  assign m_tlast_o  = last_q;
  assign m_tdata_o  = (kind_q == KIND_PAYLOAD)
                    ? {1'b0, word, 7'b0, 16'b0, 16'b0, 32'b0, 32'b0}
                    : {1'b0, 64'b0, 7'(size_q), rec_q.dport, rec_q.sport,
                       rec_q.dst_ip, rec_q.src_ip};

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the TCP port payload capture core: frame stimulus, record prediction, checks.
module tb_top;
  import tppc_pkg::*;

  localparam int unsigned CaptureBytes   = 64;
  localparam int unsigned MaxFrameBytes  = 2048;
  localparam int unsigned WordsPerRecord = (CaptureBytes + 7) / 8;
  localparam int unsigned TcpHeadBytes   = DoffOff - TcpBase + 1;
  localparam int unsigned IdlePct        = 31;
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned CycleLimit     = 600000;
  localparam int unsigned ReportMax      = 10;

  typedef logic [7:0] byte_q_t[$];

  // One record item as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [6:0]  size;
    logic [63:0] word;
    logic        last;
  } record_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // data_byte
  logic                   s_axis_tlast  = 1'b0;  // frame_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // source IP, destination IP, source port, destination port, captured size,
  // payload word, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;  // record_kind
  logic                   m_axis_tlast;  // record_last
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_addr_i    = 1'b0;
  logic [15:0]            cfg_wdata_i   = '0;

  tcp_port_payload_capture_core #(
    .CAPTURE_BYTES  (CaptureBytes),
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration and of the per-frame parse state
  logic [15:0]  cfg_port = '0;
  logic         cfg_on   = 1'b0;
  int unsigned  frame_pos;
  logic [15:0]  etype_seen;
  logic [31:0]  src_addr_seen;
  logic [31:0]  dst_addr_seen;
  logic [15:0]  sport_seen;
  logic [15:0]  dport_seen;
  logic [3:0]   doff_seen;
  logic         frame_dropped;
  logic [7:0]   pay_bytes [CaptureBytes];
  logic [7:0]   tcp_head  [TcpHeadBytes];

  record_t      expected_records[$];
  bit           steady;
  int unsigned  cycles;
  int unsigned  mismatches;
  int unsigned  items_checked;
  int unsigned  frames_sent;
  int unsigned  bytes_sent;
  int unsigned  records_expected;

  function automatic void clear_frame_state();
    frame_pos     = 0;
    etype_seen    = '0;
    src_addr_seen = '0;
    dst_addr_seen = '0;
    sport_seen    = '0;
    dport_seen    = '0;
    doff_seen     = '0;
    frame_dropped = 1'b0;
    foreach (pay_bytes[i]) pay_bytes[i] = '0;
    foreach (tcp_head[i]) tcp_head[i] = '0;
  endfunction

  // Parse one accepted byte; at frame end queue the capture record it earns
  function automatic void predict_capture(logic [7:0] b, logic last);
    int unsigned o;
    int unsigned start;
    int unsigned len;
    int unsigned size;
    record_t     r;
    logic [63:0] w;
    if (frame_pos < MaxFrameBytes) begin
      o = frame_pos;
      if (o == EtherTypeHiOff || o == EtherTypeLoOff) etype_seen = {etype_seen[7:0], b};
      if (o == EtherTypeLoOff && etype_seen != ETH_TYPE_IPV4) frame_dropped = 1'b1;
      if (o == IpProtoOff && b != IP_PROTO_TCP) frame_dropped = 1'b1;
      if (o >= SrcIpFirstOff && o <= SrcIpLastOff) src_addr_seen = {src_addr_seen[23:0], b};
      if (o >= DstIpFirstOff && o <= DstIpLastOff) dst_addr_seen = {dst_addr_seen[23:0], b};
      if (o == TcpBase || o == SrcPortLastOff) sport_seen = {sport_seen[7:0], b};
      if (o == DstPortFirstOff || o == DstPortLastOff) dport_seen = {dport_seen[7:0], b};
      if (o >= TcpBase && o <= DoffOff) tcp_head[o - TcpBase] = b;
      if (o == DoffOff) doff_seen = b[7:4];
      if (o > DoffOff) begin
        start = TcpBase + doff_seen * 4;
        if (o >= start && o - start < CaptureBytes) pay_bytes[o - start] = b;
      end
      frame_pos++;
    end
    if (!last) return;

    len   = frame_pos;
    start = TcpBase + doff_seen * 4;
    if (len >= MinFrame && !frame_dropped && cfg_on &&
        (sport_seen == cfg_port || dport_seen == cfg_port) && len > start) begin
      size = len - start;
      if (size > CaptureBytes) size = CaptureBytes;
      // Payload that began inside the TCP header comes from the held header bytes
      for (o = start; o <= DoffOff; o++)
        if (o - start < CaptureBytes) pay_bytes[o - start] = tcp_head[o - TcpBase];
      r        = '0;
      r.kind   = KIND_HEADER;
      r.src_ip = src_addr_seen;
      r.dst_ip = dst_addr_seen;
      r.sport  = sport_seen;
      r.dport  = dport_seen;
      r.size   = 7'(size);
      expected_records.push_back(r);
      records_expected++;
      for (int unsigned wi = 0; wi < WordsPerRecord; wi++) begin
        w = '0;
        for (int unsigned k = 0; k < 8; k++)
          if (wi * 8 + k < size) w[8*k +: 8] = pay_bytes[wi * 8 + k];
        r      = '0;
        r.kind = KIND_PAYLOAD;
        r.word = w;
        r.last = (wi == WordsPerRecord - 1);
        expected_records.push_back(r);
      end
    end
    clear_frame_state();
  endfunction

  function automatic string fmt_record(record_t r);
    return $sformatf("kind %0d src_ip %h dst_ip %h sport %h dport %h size %0d word %h last %0d",
                     r.kind, r.src_ip, r.dst_ip, r.sport, r.dport, r.size, r.word, r.last);
  endfunction

  // Build a frame with the given header fields; all other bytes random
  function automatic byte_q_t make_frame(int unsigned len, logic [15:0] etype,
                                         logic [7:0] proto, logic [31:0] sip, logic [31:0] dip,
                                         logic [15:0] sp, logic [15:0] dp, logic [3:0] doff);
    byte_q_t f;
    int unsigned n;
    n = (len < DoffOff + 1) ? DoffOff + 1 : len;
    for (int unsigned i = 0; i < n; i++) f.push_back(8'($urandom));
    f[EtherTypeHiOff] = etype[15:8];
    f[EtherTypeLoOff] = etype[7:0];
    f[IpProtoOff]     = proto;
    for (int unsigned i = 0; i < 4; i++) begin
      f[SrcIpFirstOff + i] = sip[31 - 8*i -: 8];
      f[DstIpFirstOff + i] = dip[31 - 8*i -: 8];
    end
    f[TcpBase]         = sp[15:8];
    f[SrcPortLastOff]  = sp[7:0];
    f[DstPortFirstOff] = dp[15:8];
    f[DstPortLastOff]  = dp[7:0];
    f[DoffOff]         = {doff, f[DoffOff][3:0]};
    while (f.size() > len) void'(f.pop_back());
    return f;
  endfunction

  function automatic byte_q_t fill_tail(byte_q_t f, int unsigned from, logic [7:0] v);
    for (int unsigned i = from; i < f.size(); i++) f[i] = v;
    return f;
  endfunction

  // Offer one item, idling at random first; return once it is accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_capture(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // Hold off the sender until every expected item has come and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CFG_TARGET_PORT) cfg_port = val;
    else cfg_on = val[0];
    @(posedge clk_i);
  endtask

  // Sink side: stall at random unless a steady stretch is running
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Compare each record item with the oldest expectation
  always @(posedge clk_i) begin : check_records
    record_t got;
    record_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = m_axis_tuser;
      got.src_ip = m_axis_tdata[31:0];
      got.dst_ip = m_axis_tdata[63:32];
      got.sport  = m_axis_tdata[79:64];
      got.dport  = m_axis_tdata[95:80];
      got.size   = m_axis_tdata[102:96];
      got.word   = m_axis_tdata[166:103];
      got.last   = m_axis_tlast;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) $display("unexpected item: %s", fmt_record(got));
      end else begin
        want = expected_records.pop_front();
        items_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= ReportMax) begin
            $display("mismatch at item %0d", items_checked);
            $display("  expected %s", fmt_record(want));
            $display("  actual   %s", fmt_record(got));
          end
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycles, expected_records.size());
      $display("FAIL tcp_port_payload_capture_core");
      $finish;
    end
  end

  // Capture stays off straight after reset
  task automatic test_reset_disabled();
    send_frame(make_frame(55, ETH_TYPE_IPV4, IP_PROTO_TCP, 32'($urandom), 32'($urandom),
                          16'h0000, 16'h0000, 4'd5));
    settle();
  endtask

  // Short, saturated, empty and wrong-type frames with the target port on either side
  task automatic test_directed_frames();
    logic [15:0] p;
    logic [15:0] q;
    p = 16'h1F90;
    q = 16'h0050;
    write_reg(CFG_TARGET_PORT, p);
    write_reg(CFG_PORT_ON, 16'h0001);
    // One-byte frame
    send_byte(8'h00, 1'b1);
    // Payload from inside the TCP header, size saturated, all-ones fields
    send_frame(fill_tail(make_frame(99, ETH_TYPE_IPV4, IP_PROTO_TCP, '1, '1, 16'hFFFF, p,
                                    4'd0), 54, 8'hFF));
    // Empty payload
    send_frame(make_frame(54, ETH_TYPE_IPV4, IP_PROTO_TCP, 32'($urandom), 32'($urandom),
                          p, q, 4'd5));
    // Wrong ethertype
    send_frame(make_frame(55, 16'h86DD, IP_PROTO_TCP, 32'($urandom), 32'($urandom),
                          p, p, 4'd5));
    settle();
  endtask

  // Register extreme: port all ones, single payload byte, zero addresses
  task automatic test_register_extremes();
    write_reg(CFG_TARGET_PORT, 16'hFFFF);
    send_frame(make_frame(55, ETH_TYPE_IPV4, IP_PROTO_TCP, '0, '0,
                          16'h1234, 16'hFFFF, 4'd5));
    settle();
  endtask

  // Matching frames back to back with no idling on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    for (int i = 0; i < 2; i++)
      send_frame(make_frame($urandom_range(55, 58), ETH_TYPE_IPV4, IP_PROTO_TCP,
                            32'($urandom), 32'($urandom), cfg_port,
                            (i % 2) ? cfg_port : 16'(~cfg_port), 4'd5));
    settle();
    steady = 1'b0;
  endtask

  initial begin
    clear_frame_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_disabled();
    test_directed_frames();
    test_register_extremes();
    test_back_to_back();

    settle();
    $display("sent %0d frames (%0d bytes); %0d capture records expected, %0d items checked",
             frames_sent, bytes_sent, records_expected, items_checked);
    $display("covered capture off after reset, short, empty and wrong-type frames, "
             , "saturated size, payload inside the TCP header, back-to-back records");
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("PASS tcp_port_payload_capture_core");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL tcp_port_payload_capture_core");
    end
    $finish;
  end

endmodule
